// File: rtl/pld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the polyline densifier.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int MAX_INSERTS_DEF = 31;

    // inserts_per_segment register width
    localparam int INS_BITS = 5;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic             CLOSED_RESET  = 1'b1;
    localparam logic [INS_BITS-1:0] INSERTS_RESET = 5'd2;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_CLOSED  = 1'b0,
        REG_INSERTS = 1'b1
    } pld_reg_t;

    typedef struct packed {
        logic                closed;
        logic [INS_BITS-1:0] inserts;
    } pld_cfg_t;

    typedef struct packed {
        logic load;   // take quotient and remainder of the step
        logic init;   // start the segment at its first vertex
        logic step;   // advance to the next point
    } pld_lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_GO,
        ST_ROW_WAIT,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_EMIT,
        ST_SINGLE
    } pld_state_t;

endpackage
`default_nettype wire

// File: rtl/pld_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pld_cfg
// APB register file: closed_curve and inserts_per_segment.
// ----------------------------------------------------------------------------
module pld_cfg
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pld_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [pld_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [pld_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    output pld_pkg::pld_cfg_t                       cfg
);

    logic                          closed_reg;
    logic [pld_pkg::INS_BITS-1:0]  inserts_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg  <= pld_pkg::CLOSED_RESET;
            inserts_reg <= pld_pkg::INSERTS_RESET;
        end
        else if (wr_en)
        begin
            unique case (pld_pkg::pld_reg_t'(paddr[2]))
                pld_pkg::REG_CLOSED:  closed_reg  <= pwdata[0];
                pld_pkg::REG_INSERTS: inserts_reg <= pwdata[pld_pkg::INS_BITS-1:0];
                default:              closed_reg  <= closed_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (pld_pkg::pld_reg_t'(paddr[2]))
            pld_pkg::REG_CLOSED:
                prdata = {{(pld_pkg::APB_DATA_BITS-1){1'b0}}, closed_reg};
            pld_pkg::REG_INSERTS:
                prdata = {{(pld_pkg::APB_DATA_BITS-pld_pkg::INS_BITS){1'b0}}, inserts_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.closed  = closed_reg;
    assign cfg.inserts = inserts_reg;

endmodule
`default_nettype wire

// File: rtl/pld_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pld_div
// Shared restoring divider: signed dividend by small unsigned divisor,
// one quotient bit per cycle, floor quotient with remainder in [0, divisor).
// ----------------------------------------------------------------------------
module pld_div #(
    parameter int DW = 17,
    parameter int SW = 6
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [SW-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [DW-1:0]      quot,
    output logic [SW-1:0]      rmd
);

    localparam int CNT_BITS = $clog2(DW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DW-1:0]       work_reg;
    logic [SW-1:0]       rem_reg;
    logic [SW-1:0]       div_reg;
    logic                neg_reg;

    logic [SW:0]         trial;
    logic                ge;
    logic [SW:0]         diff;

    assign trial = {rem_reg, work_reg[DW-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // divide the magnitude, fix the sign at the end
            work_reg <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
            neg_reg  <= dividend[DW-1];
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[SW-1:0] : trial[SW-1:0];
            work_reg <= {work_reg[DW-2:0], ge};
        end
    end

    // floor correction for a negative dividend: -(m+1) is ~m
    assign quot = (neg_reg && rem_reg != '0) ? ~work_reg :
                  (neg_reg ? (~work_reg + 1'b1) : work_reg);
    assign rmd  = (neg_reg && rem_reg != '0) ? (div_reg - rem_reg) : rem_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// File: rtl/pld_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pld_lane
// Point stepper for one coordinate: keeps the floor quotient and remainder
// of the running numerator and adds the per-point step each advance.
// ----------------------------------------------------------------------------
module pld_lane #(
    parameter int CW = 16,
    parameter int SW = 6
)
(
    input  wire logic                   clk,
    input  wire pld_pkg::pld_lane_ctl_t ctl,
    input  wire logic [CW-1:0]          start_val,
    input  wire logic [CW:0]            div_quot,
    input  wire logic [SW-1:0]          div_rmd,
    input  wire logic [SW-1:0]          steps,
    output logic      [CW-1:0]          point
);

    logic [CW:0]   q_reg;
    logic [SW-1:0] r_reg;
    logic [CW:0]   dq_reg;
    logic [SW-1:0] dr_reg;

    logic [SW:0]   sum;
    logic          wrap;
    logic [SW:0]   sum_wrapped;
    logic [CW:0]   trunc;

    assign sum         = {1'b0, r_reg} + {1'b0, dr_reg};
    assign wrap        = sum >= {1'b0, steps};
    assign sum_wrapped = sum - {1'b0, steps};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            dq_reg <= div_quot;
            dr_reg <= div_rmd;
        end
        if (ctl.init)
        begin
            q_reg <= {start_val[CW-1], start_val};
            r_reg <= '0;
        end
        else if (ctl.step)
        begin
            q_reg <= q_reg + dq_reg + {{CW{1'b0}}, wrap};
            r_reg <= wrap ? sum_wrapped[SW-1:0] : sum[SW-1:0];
        end
    end

    // floor to truncation: round a negative inexact quotient up
    assign trunc = q_reg + {{CW{1'b0}}, (q_reg[CW] && r_reg != '0)};
    assign point = trunc[CW-1:0];

endmodule
`default_nettype wire

// File: rtl/polyline_linear_densifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_linear_densifier_top
// Resamples a polyline: emits each segment's start vertex and evenly spaced
// inserted points, closing the curve back to the first vertex when enabled.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_*       in    tvalid/tready      tdata {col,row}, tlast final_vertex
//  m_*       out   tvalid/tready      tdata {col,row}, tlast run_end,
//                                     tuser curve_end
//  apb       in    psel/penable       closed_curve @0, inserts_per_segment @4
//
//  Each segment takes two passes through the shared divider (row and column
//  step) and then emits one point per cycle while m_tready does not stall.
//  s_tready is high only while the sequencer is idle; a stalled m_tready
//  holds the output register and the sequencer. Reset is asynchronous,
//  active low, and clears the sequencer, the held-vertex flag and the output
//  valid flag.
// ----------------------------------------------------------------------------
module polyline_linear_densifier_top #(
    parameter int COORD_BITS  = pld_pkg::COORD_BITS_DEF,
    parameter int MAX_INSERTS = pld_pkg::MAX_INSERTS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // vertex_row, vertex_col, zero pad
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tlast,
    output logic                                    s_tready,
    // point_row, point_col, zero pad
    output logic      [((2*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    output logic                                    m_tvalid,
    output logic                                    m_tlast,
    // curve_end
    output logic      [0:0]                         m_tuser,
    input  wire logic                               m_tready,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pld_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [pld_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [pld_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready
);

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int SW  = $clog2(MAX_INSERTS + 2);
    localparam int TDW = ((2*CW+7)/8)*8;
    localparam int IB  = pld_pkg::INS_BITS;

    pld_pkg::pld_cfg_t      cfg;
    pld_pkg::pld_state_t    state_reg, state_next;
    pld_pkg::pld_lane_ctl_t row_ctl, col_ctl;

    logic          have_reg, have_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic          out_run_reg, out_run_next;
    logic          out_curve_reg, out_curve_next;

    logic [CW-1:0] first_row_reg, first_row_next;
    logic [CW-1:0] first_col_reg, first_col_next;
    logic [CW-1:0] prev_row_reg, prev_row_next;
    logic [CW-1:0] prev_col_reg, prev_col_next;
    logic [CW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic          fin_reg, fin_next;
    logic [CW-1:0] a_row_reg, a_row_next;
    logic [CW-1:0] a_col_reg, a_col_next;
    logic [CW-1:0] b_row_reg, b_row_next;
    logic [CW-1:0] b_col_reg, b_col_next;
    logic          closing_reg, closing_next;
    logic [IB-1:0] k_reg, k_next;

    logic [CW-1:0] in_row, in_col;
    logic [IB-1:0] max_ins, n_sat;
    logic [SW-1:0] steps;
    logic          out_free;
    logic          last_pt;
    logic          run_end;

    logic          div_start, div_busy, div_done;
    logic [DW-1:0] div_dividend, div_quot;
    logic [SW-1:0] div_rmd;
    logic [CW-1:0] row_point, col_point;

    assign in_row  = s_tdata[CW-1:0];
    assign in_col  = s_tdata[2*CW-1:CW];
    assign max_ins = IB'(MAX_INSERTS);
    assign n_sat   = (cfg.inserts > max_ins) ? max_ins : cfg.inserts;
    assign steps   = SW'(n_sat) + SW'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign last_pt  = (k_reg == n_sat);
    assign run_end  = last_pt && (closing_reg || !fin_reg);

    assign div_start    = (state_reg == pld_pkg::ST_ROW_GO) ||
                          (state_reg == pld_pkg::ST_COL_GO);
    assign div_dividend = (state_reg == pld_pkg::ST_ROW_GO) ?
                          ({b_row_reg[CW-1], b_row_reg} - {a_row_reg[CW-1], a_row_reg}) :
                          ({b_col_reg[CW-1], b_col_reg} - {a_col_reg[CW-1], a_col_reg});

    pld_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pld_div #(.DW(DW), .SW(SW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (steps),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rmd      (div_rmd)
    );

    pld_lane #(.CW(CW), .SW(SW)) u_lane_row
    (
        .clk       (clk),
        .ctl       (row_ctl),
        .start_val (a_row_reg),
        .div_quot  (div_quot),
        .div_rmd   (div_rmd),
        .steps     (steps),
        .point     (row_point)
    );

    pld_lane #(.CW(CW), .SW(SW)) u_lane_col
    (
        .clk       (clk),
        .ctl       (col_ctl),
        .start_val (a_col_reg),
        .div_quot  (div_quot),
        .div_rmd   (div_rmd),
        .steps     (steps),
        .point     (col_point)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pld_pkg::ST_IDLE;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_run_reg   <= out_run_next;
        out_curve_reg <= out_curve_next;
        first_row_reg <= first_row_next;
        first_col_reg <= first_col_next;
        prev_row_reg  <= prev_row_next;
        prev_col_reg  <= prev_col_next;
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        fin_reg       <= fin_next;
        a_row_reg     <= a_row_next;
        a_col_reg     <= a_col_next;
        b_row_reg     <= b_row_next;
        b_col_reg     <= b_col_next;
        closing_reg   <= closing_next;
        k_reg         <= k_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_run_next   = out_run_reg;
        out_curve_next = out_curve_reg;
        first_row_next = first_row_reg;
        first_col_next = first_col_reg;
        prev_row_next  = prev_row_reg;
        prev_col_next  = prev_col_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        fin_next       = fin_reg;
        a_row_next     = a_row_reg;
        a_col_next     = a_col_reg;
        b_row_next     = b_row_reg;
        b_col_next     = b_col_reg;
        closing_next   = closing_reg;
        k_next         = k_reg;
        s_tready       = 1'b0;
        row_ctl        = '0;
        col_ctl        = '0;

        unique case (state_reg)
            pld_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cur_row_next  = in_row;
                    cur_col_next  = in_col;
                    fin_next      = s_tlast;
                    prev_row_next = in_row;
                    prev_col_next = in_col;
                    have_next     = !s_tlast;
                    if (have_reg)
                    begin
                        a_row_next   = prev_row_reg;
                        a_col_next   = prev_col_reg;
                        b_row_next   = in_row;
                        b_col_next   = in_col;
                        closing_next = 1'b0;
                        state_next   = pld_pkg::ST_ROW_GO;
                    end
                    else
                    begin
                        first_row_next = in_row;
                        first_col_next = in_col;
                        if (s_tlast && cfg.closed)
                        begin
                            // single vertex, closed: segment onto itself
                            a_row_next   = in_row;
                            a_col_next   = in_col;
                            b_row_next   = in_row;
                            b_col_next   = in_col;
                            closing_next = 1'b1;
                            state_next   = pld_pkg::ST_ROW_GO;
                        end
                        else if (s_tlast)
                        begin
                            state_next = pld_pkg::ST_SINGLE;
                        end
                    end
                end
            end

            pld_pkg::ST_ROW_GO:
                state_next = pld_pkg::ST_ROW_WAIT;

            pld_pkg::ST_ROW_WAIT:
            begin
                if (div_done)
                begin
                    row_ctl.load = 1'b1;
                    state_next   = pld_pkg::ST_COL_GO;
                end
            end

            pld_pkg::ST_COL_GO:
                state_next = pld_pkg::ST_COL_WAIT;

            pld_pkg::ST_COL_WAIT:
            begin
                if (div_done)
                begin
                    col_ctl.load = 1'b1;
                    row_ctl.init = 1'b1;
                    col_ctl.init = 1'b1;
                    k_next       = '0;
                    state_next   = pld_pkg::ST_EMIT;
                end
            end

            pld_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_point;
                    out_col_next   = col_point;
                    out_run_next   = run_end;
                    out_curve_next = run_end && fin_reg;
                    row_ctl.step   = 1'b1;
                    col_ctl.step   = 1'b1;
                    k_next         = k_reg + 1'b1;
                    if (last_pt)
                    begin
                        if (run_end)
                        begin
                            state_next = pld_pkg::ST_IDLE;
                        end
                        else if (cfg.closed)
                        begin
                            // close back to the first vertex
                            a_row_next   = cur_row_reg;
                            a_col_next   = cur_col_reg;
                            b_row_next   = first_row_reg;
                            b_col_next   = first_col_reg;
                            closing_next = 1'b1;
                            state_next   = pld_pkg::ST_ROW_GO;
                        end
                        else
                        begin
                            state_next = pld_pkg::ST_SINGLE;
                        end
                    end
                end
            end

            pld_pkg::ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = cur_row_reg;
                    out_col_next   = cur_col_reg;
                    out_run_next   = 1'b1;
                    out_curve_next = 1'b1;
                    state_next     = pld_pkg::ST_IDLE;
                end
            end

            default:
                state_next = pld_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'({out_col_reg, out_row_reg});
    assign m_tlast  = out_run_reg;
    assign m_tuser  = out_curve_reg;

    a_curve_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("curve_end without run_end");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == pld_pkg::ST_ROW_WAIT || state_reg == pld_pkg::ST_COL_WAIT))
        else $error("divider result outside a wait state");

    a_held_vertex_segment: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && have_reg |=> state_reg == pld_pkg::ST_ROW_GO)
        else $error("vertex after a held vertex did not start a segment");

    a_final_clears_have: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !have_reg)
        else $error("final vertex left a vertex held");

endmodule
`default_nettype wire

// File: dv/polyline_linear_densifier_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_linear_densifier_top_tb
// Streams polylines into the densifier under several curve settings and
// checks every dense point against a behavioral predictor, with random
// idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module polyline_linear_densifier_top_tb;

    localparam int CB             = pld_pkg::COORD_BITS_DEF;
    localparam int MAX_INS        = pld_pkg::MAX_INSERTS_DEF;
    localparam int DATA_W         = ((2*CB+7)/8)*8;
    localparam int AW             = pld_pkg::APB_ADDR_BITS;
    localparam int PW             = pld_pkg::APB_DATA_BITS;
    localparam int IW             = pld_pkg::INS_BITS;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 160;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
        logic   run_end;
        logic   curve_end;
    } dense_point_t;

    logic                     clk;
    logic                     rst_n;
    logic [DATA_W-1:0]        s_tdata;    // vertex_row, vertex_col
    logic                     s_tvalid;
    logic                     s_tlast;
    logic                     s_tready;
    logic [DATA_W-1:0]        m_tdata;    // point_row, point_col
    logic                     m_tvalid;
    logic                     m_tlast;
    logic [0:0]               m_tuser;    // curve_end
    logic                     m_tready = 1'b0;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [AW-1:0]            paddr;
    logic [PW-1:0]            pwdata;
    logic [PW-1:0]            prdata;
    logic                     pready;

    polyline_linear_densifier_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic          cfg_closed  = pld_pkg::CLOSED_RESET;
    logic [IW-1:0] cfg_inserts = pld_pkg::INSERTS_RESET;
    coord_t        first_row, first_col, prev_row, prev_col;
    logic          have_vertex = 1'b0;

    dense_point_t expected_points[$];
    dense_point_t new_points[$];

    int  err_count      = 0;
    int  vertices_sent  = 0;
    int  polylines_sent = 0;
    int  points_checked = 0;
    int  quiet_cycles   = 0;
    int  stall_request  = 0;
    int  stall_left     = 0;
    bit  src_idle_en    = 1'b1;
    bit  sink_idle_en   = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic coord_t lerp_coord(input longint a, input longint b,
                                          input int k, input int steps);
        longint acc;
        acc = (a * (steps - k) + b * k) / steps;
        return coord_t'(acc);
    endfunction

    task automatic add_segment(input coord_t ar, input coord_t ac, input coord_t br,
                               input coord_t bc, input int n);
        dense_point_t pt;
        for (int k = 0; k <= n; k++)
        begin
            pt.row       = lerp_coord(ar, br, k, n + 1);
            pt.col       = lerp_coord(ac, bc, k, n + 1);
            pt.run_end   = 1'b0;
            pt.curve_end = 1'b0;
            new_points   = {new_points, pt};
        end
    endtask

    task automatic predict_vertex(input coord_t r, input coord_t c, input logic fin);
        int           n;
        dense_point_t pt;
        n = (cfg_inserts > MAX_INS) ? MAX_INS : int'(cfg_inserts);
        new_points.delete();
        if (!have_vertex)
        begin
            first_row = r;
            first_col = c;
        end
        else
        begin
            add_segment(prev_row, prev_col, r, c, n);
        end
        if (fin)
        begin
            if (cfg_closed)
            begin
                add_segment(r, c, first_row, first_col, n);
            end
            else
            begin
                pt = '{row: r, col: c, run_end: 1'b0, curve_end: 1'b0};
                new_points = {new_points, pt};
            end
            have_vertex = 1'b0;
        end
        else
        begin
            have_vertex = 1'b1;
        end
        prev_row = r;
        prev_col = c;
        // mark the last point of this vertex's run
        if (new_points.size() > 0)
        begin
            pt           = new_points.pop_back();
            pt.run_end   = 1'b1;
            pt.curve_end = fin;
            new_points   = {new_points, pt};
        end
        expected_points = {expected_points, new_points};
    endtask

    task automatic send_vertex(input coord_t r, input coord_t c, input logic fin);
        while (src_idle_en && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {c, r};
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_vertex(r, c, fin);
        vertices_sent++;
        if (fin)
        begin
            polylines_sent++;
        end
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'(-32768);
            1:       return coord_t'(32767);
            2:       return coord_t'(-1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_polyline(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_vertex(random_coord(), random_coord(), i == len - 1);
        end
    endtask

    // drop valid, then wait for every expected point plus a settle gap
    task automatic finish_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input pld_pkg::pld_reg_t idx, input logic [PW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == pld_pkg::REG_CLOSED)
        begin
            cfg_closed = value[0];
        end
        else
        begin
            cfg_inserts = value[IW-1:0];
        end
    endtask

    task automatic apb_check(input pld_pkg::pld_reg_t idx, input logic [PW-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            report_mismatch(idx == pld_pkg::REG_CLOSED ? "closed_curve read" : "inserts read",
                            prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits carry junk; the block keeps only the field bits
    task automatic set_curve(input logic closed, input int n);
        apb_write(pld_pkg::REG_CLOSED, ($urandom << 1) | PW'(closed));
        apb_write(pld_pkg::REG_INSERTS, ($urandom << IW) | PW'(n));
        apb_check(pld_pkg::REG_CLOSED, {{(PW-1){1'b0}}, closed});
        apb_check(pld_pkg::REG_INSERTS, {{(PW-IW){1'b0}}, n[IW-1:0]});
    endtask

    // sink side: check each point, then pick the next ready level
    always @(posedge clk)
    begin
        dense_point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected point", 32'(m_tdata), 32'h0);
            end
            else
            begin
                want = expected_points.pop_front();
                points_checked++;
                if (m_tdata[CB-1:0] !== want.row)
                begin
                    report_mismatch("point_row", 32'(m_tdata[CB-1:0]), 32'(want.row));
                end
                if (m_tdata[2*CB-1:CB] !== want.col)
                begin
                    report_mismatch("point_col", 32'(m_tdata[2*CB-1:CB]), 32'(want.col));
                end
                if (m_tlast !== want.run_end)
                begin
                    report_mismatch("run_end", 32'(m_tlast), 32'(want.run_end));
                end
                if (m_tuser[0] !== want.curve_end)
                begin
                    report_mismatch("curve_end", 32'(m_tuser[0]), 32'(want.curve_end));
                end
            end
        end
        if (stall_request > 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 99) < 36)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        apb_check(pld_pkg::REG_CLOSED, {{(PW-1){1'b0}}, pld_pkg::CLOSED_RESET});
        apb_check(pld_pkg::REG_INSERTS, {{(PW-IW){1'b0}}, pld_pkg::INSERTS_RESET});
        send_vertex(0, 0, 1'b0);
        send_vertex(9, -9, 1'b0);
        send_vertex(-7, 4, 1'b1);
        send_vertex(32767, -32768, 1'b1);
        finish_stream();
    endtask

    task automatic test_open_curves();
        set_curve(1'b0, 2);
        send_vertex(-32768, 32767, 1'b1);
        send_vertex(32767, 32767, 1'b0);
        send_vertex(-32768, -32768, 1'b1);
        finish_stream();
    endtask

    task automatic test_insert_extremes();
        set_curve(1'b1, 0);
        send_vertex(100, -100, 1'b0);
        send_vertex(-1, 1, 1'b0);
        send_vertex(5, 5, 1'b1);
        finish_stream();
        set_curve(1'b1, MAX_INS);
        send_vertex(-32768, 32767, 1'b0);
        send_vertex(32767, -32768, 1'b1);
        finish_stream();
        set_curve(1'b0, MAX_INS);
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(32767, 32767, 1'b0);
        send_vertex(0, -1, 1'b1);
        finish_stream();
        // odd spans with negative ends exercise truncation toward zero
        set_curve(1'b1, 1);
        send_vertex(-3, 3, 1'b0);
        send_vertex(4, -4, 1'b1);
        finish_stream();
    endtask

    task automatic test_random_polylines();
        int start;
        int n;
        start = vertices_sent;
        while (vertices_sent - start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       n = MAX_INS;
                1:       n = $urandom_range(0, MAX_INS);
                2, 3, 4: n = $urandom_range(4, 8);
                default: n = $urandom_range(0, 3);
            endcase
            set_curve(1'($urandom_range(0, 1)), n);
            repeat ($urandom_range(1, 4))
            begin
                send_polyline(($urandom_range(0, 99) < 15) ? 1 : $urandom_range(2, 6));
            end
            finish_stream();
        end
    endtask

    task automatic test_output_hold();
        set_curve(1'b1, 6);
        src_idle_en   = 1'b0;
        stall_request = 300;
        send_polyline(5);
        send_polyline(4);
        finish_stream();
        src_idle_en = 1'b1;
    endtask

    task automatic test_back_to_back();
        set_curve(1'b0, 1);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (5) send_polyline($urandom_range(1, 5));
        finish_stream();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tdata  <= '0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_reset_defaults();
        test_open_curves();
        test_insert_extremes();
        test_random_polylines();
        test_output_hold();
        test_back_to_back();

        $display("Checked %0d dense points from %0d vertices in %0d polylines",
                 points_checked, vertices_sent, polylines_sent);
        $display("Covered open and closed curves, 0 to 31 inserts, output hold, no-gap streams");
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
